### sv/lfrr_pkg.sv
// Shared constants and types for the login frame refuse responder.
`default_nettype none

package lfrr_pkg;

  // Frame delimiters and codes
  localparam logic [7:0] FRAME_HEAD  = 8'h02;
  localparam logic [7:0] FRAME_TAIL  = 8'h03;
  localparam logic [7:0] CMD_LOGIN   = 8'hA0;
  localparam logic [7:0] ACK_CODE    = 8'hA5;
  localparam logic [7:0] REFUSE_CODE = 8'h57;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;
  localparam logic [7:0] REPLY_LEN   = 8'h0A;

  // Byte count saturation and thresholds
  localparam logic [3:0] POS_SAT     = 4'd8;
  localparam logic [3:0] MIN_FRAME   = 4'd6;
  localparam logic [3:0] MIN_LOGIN   = 4'd8;

  // Byte positions inside the received frame
  localparam logic [3:0] POS_HEAD    = 4'd0;
  localparam logic [3:0] POS_CMD     = 4'd2;
  localparam logic [3:0] POS_SER_LO  = 4'd3;
  localparam logic [3:0] POS_SER_HI  = 4'd6;

  // Byte positions inside the reply frame
  localparam logic [3:0] RP_HEAD     = 4'd0;
  localparam logic [3:0] RP_LEN      = 4'd1;
  localparam logic [3:0] RP_ACK      = 4'd2;
  localparam logic [3:0] RP_REFUSE   = 4'd3;
  localparam logic [3:0] RP_S3       = 4'd4;
  localparam logic [3:0] RP_S2       = 4'd5;
  localparam logic [3:0] RP_S1       = 4'd6;
  localparam logic [3:0] RP_S0       = 4'd7;
  localparam logic [3:0] RP_CHK      = 4'd8;
  localparam logic [3:0] RP_TAIL     = 4'd9;

  // Sum of the fixed reply bytes: head, length, ack and refuse codes
  localparam logic [7:0] CHK_BASE    = 8'(FRAME_HEAD + REPLY_LEN + ACK_CODE + REFUSE_CODE);

  // Default depth of the queue between parser and sender
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // A refuse request handed from the parser to the queue
  typedef struct packed {
    logic        push;
    logic [31:0] serial;
  } lfrr_req_t;

endpackage : lfrr_pkg

`default_nettype wire

### sv/lfrr_parser.sv
// Front end: parses received bytes and flags login requests to be refused.
`default_nettype none

module lfrr_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              rx_last_i,
  output lfrr_pkg::lfrr_req_t    req_o
);
  import lfrr_pkg::*;

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        header_q, header_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] serial_q, serial_d;
  logic        frame_ok;

  // Per-byte update of the frame state
  always_comb begin
    header_d = header_q;
    cmd_d    = cmd_q;
    serial_d = serial_q;
    if (pos_q == POS_HEAD) begin
      header_d = (rx_byte_i == FRAME_HEAD);
    end
    if (pos_q == POS_CMD) begin
      cmd_d = rx_byte_i;
    end
    if (pos_q >= POS_SER_LO && pos_q <= POS_SER_HI) begin
      serial_d = {serial_q[23:0], rx_byte_i};
    end
    sum_d = sum_q + rx_byte_i;
    pos_d = (pos_q < POS_SAT) ? pos_q + 4'd1 : POS_SAT;
  end

  // Checks on the final byte: sum before the tail must be all ones
  assign frame_ok = header_d && (rx_byte_i == FRAME_TAIL) && (pos_d >= MIN_FRAME) &&
                    (sum_q == SUM_GOOD) && (cmd_d == CMD_LOGIN) && (pos_d >= MIN_LOGIN);

  assign req_o.push   = accept_i && rx_last_i && frame_ok;
  assign req_o.serial = serial_d;

  // Frame state; cleared after every final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      header_q <= 1'b0;
      cmd_q    <= '0;
      serial_q <= '0;
    end else if (accept_i) begin
      if (rx_last_i) begin
        pos_q    <= '0;
        sum_q    <= '0;
        header_q <= 1'b0;
        cmd_q    <= '0;
        serial_q <= '0;
      end else begin
        pos_q    <= pos_d;
        sum_q    <= sum_d;
        header_q <= header_d;
        cmd_q    <= cmd_d;
        serial_q <= serial_d;
      end
    end
  end

endmodule : lfrr_parser

`default_nettype wire

### sv/lfrr_queue.sv
// Short FIFO of pending refuse requests between parser and sender.
`default_nettype none

module lfrr_queue #(
  parameter int unsigned Depth = lfrr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lfrr_pkg::lfrr_req_t req_i,
  input  wire logic              pop_i,
  output logic [31:0]            serial_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import lfrr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [31:0]     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o  = (cnt_q == '0);
  assign full_o   = (cnt_q == CntFull);
  assign serial_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_ptr_q] <= req_i.serial;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (req_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (req_i.push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !req_i.push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule : lfrr_queue

`default_nettype wire

### sv/lfrr_sender.sv
// Back end: sends the 10-byte refuse frame for each queued request.
`default_nettype none

module lfrr_sender (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] serial_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic [7:0]       reply_byte_o,
  output logic             reply_last_o,
  output logic             reply_valid_o,
  input  wire logic        reply_stall_i
);
  import lfrr_pkg::*;

  logic        busy_q;
  logic [3:0]  idx_q;
  logic [31:0] serial_q;
  logic [7:0]  chk_q, chk_d;
  logic        taken, done;

  assign taken = busy_q && !reply_stall_i;
  assign done  = taken && (idx_q == RP_TAIL);
  assign pop_o = !empty_i && (!busy_q || done);

  // Checksum of a new request, worked out as it is loaded
  always_comb begin
    chk_d = CHK_BASE + serial_i[31:24];
    chk_d = chk_d + serial_i[23:16];
    chk_d = chk_d + serial_i[15:8];
    chk_d = chk_d + serial_i[7:0];
    chk_d = ~chk_d;
  end

  // Reply byte selection
  always_comb begin
    unique case (idx_q)
      RP_HEAD:   reply_byte_o = FRAME_HEAD;
      RP_LEN:    reply_byte_o = REPLY_LEN;
      RP_ACK:    reply_byte_o = ACK_CODE;
      RP_REFUSE: reply_byte_o = REFUSE_CODE;
      RP_S3:     reply_byte_o = serial_q[31:24];
      RP_S2:     reply_byte_o = serial_q[23:16];
      RP_S1:     reply_byte_o = serial_q[15:8];
      RP_S0:     reply_byte_o = serial_q[7:0];
      RP_CHK:    reply_byte_o = chk_q;
      RP_TAIL:   reply_byte_o = FRAME_TAIL;
      default:   reply_byte_o = FRAME_TAIL;
    endcase
  end

  assign reply_valid_o = busy_q;
  assign reply_last_o  = busy_q && (idx_q == RP_TAIL);

  // Payload registers of the frame in flight
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      serial_q <= serial_i;
      chk_q    <= chk_d;
    end
  end

  // Sequencing through the reply bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= RP_HEAD;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= RP_HEAD;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= RP_HEAD;
    end else if (taken) begin
      idx_q  <= idx_q + 4'd1;
    end
  end

endmodule : lfrr_sender

`default_nettype wire

### sv/login_frame_refuse_responder_unit.sv
// Top level of the login frame refuse responder.
// Usage:
//   rx channel: one datagram byte per item (rx_byte_i), rx_last_i on the
//   final byte. reply channel: one byte of a refuse frame per item,
//   reply_last_o on the tenth byte.
//   A valid login frame (head 0x02, tail 0x03, at least 8 bytes, command
//   0xA0, sum of all bytes but the tail 0xFF) yields a 10-byte refuse frame.
// Throughput: one rx item per cycle while not stalled; the parser holds
//   only per-frame registers. Replies: one byte per cycle unless stalled.
// Flow: with the sender idle, the request is written into the queue at
//   the edge that accepts the final rx byte and the sender loads it at the
//   next edge, from which the first reply byte is offered; the queue holds
//   up to QueueDepth pending requests.
// Stall: a stall on the reply side only halts the sender; rx_stall_o rises
//   only once the request queue is full, so input keeps flowing until then.
// Reset: asynchronous, active low; clears frame state, queue and sender,
//   no reply in flight afterwards.
`default_nettype none

module login_frame_refuse_responder_unit #(
  parameter int unsigned QueueDepth = lfrr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       rx_last_i,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  output logic [7:0]      reply_byte_o,
  output logic            reply_last_o,
  output logic            reply_valid_o,
  input  wire logic       reply_stall_i
);
  import lfrr_pkg::*;

  lfrr_req_t   req;
  logic        rx_accept;
  logic        q_full, q_empty, q_pop;
  logic [31:0] q_serial;

  assign rx_stall_o = q_full;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  // Front: byte parser
  lfrr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_byte_i),
    .rx_last_i (rx_last_i),
    .req_o     (req)
  );

  // Request queue
  lfrr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .pop_i    (q_pop),
    .serial_o (q_serial),
    .empty_o  (q_empty),
    .full_o   (q_full)
  );

  // Back: reply sender
  lfrr_sender u_sender (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .serial_i      (q_serial),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .reply_byte_o  (reply_byte_o),
    .reply_last_o  (reply_last_o),
    .reply_valid_o (reply_valid_o),
    .reply_stall_i (reply_stall_i)
  );

  // No request is written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req.push && q_full))
    else $error("request pushed into full queue");

  // Nothing is popped from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("pop from empty queue");

  // A new reply frame starts at its head byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(reply_valid_o) |-> (reply_byte_o == FRAME_HEAD && !reply_last_o))
    else $error("reply frame does not start with head byte");

  // A reply byte held under stall does not move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (reply_valid_o && reply_stall_i) |=> (reply_valid_o && $stable(reply_byte_o)))
    else $error("stalled reply byte changed");

endmodule : login_frame_refuse_responder_unit

`default_nettype wire

### tb/login_frame_refuse_responder_unit_test.sv
// Testbench for the login frame refuse responder: datagrams checked against a built-in predictor.
module login_frame_refuse_responder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 370;
  localparam int SQUEEZE_AT   = 150;
  localparam int SQUEEZE_LEN  = 300;
  localparam int TAIL_WAIT    = 20;

  // Ways a generated frame can be broken
  typedef enum int {
    FLAW_NONE,
    FLAW_HEAD,
    FLAW_TAIL,
    FLAW_SUM
  } frame_flaw_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;  // hold this item back until every reply is out
  } rx_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } reply_item_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic [7:0] rx_byte_i     = 8'h00;
  logic       rx_last_i     = 1'b0;
  logic       rx_valid_i    = 1'b0;
  logic       reply_stall_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] reply_byte_o;
  logic       reply_last_o;
  logic       reply_valid_o;

  login_frame_refuse_responder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .rx_last_i     (rx_last_i),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .reply_byte_o  (reply_byte_o),
    .reply_last_o  (reply_last_o),
    .reply_valid_o (reply_valid_o),
    .reply_stall_i (reply_stall_i)
  );

  always #5 clk_i = ~clk_i;

  rx_item_t    pending_bytes[$];
  reply_item_t refuse_bytes[$];

  int cycle_count  = 0;
  int fail_count   = 0;
  int rx_count     = 0;
  bit rx_taken     = 1'b0;
  int rx_gap       = 0;
  int stall_left   = 0;
  int squeeze_left = 0;
  bit squeezed     = 1'b0;

  // Datagram state of the predictor
  logic [3:0]  dg_pos      = '0;
  logic [7:0]  dg_sum      = '0;
  logic [7:0]  dg_prev_sum = '0;
  logic        dg_head_ok  = 1'b0;
  logic [7:0]  dg_cmd      = '0;
  logic [31:0] dg_serial   = '0;

  // Short gaps mostly, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Windows of the run with no idling on either side
  function automatic bit calm_phase();
    return ((cycle_count / 400) % 5) == 0;
  endfunction

  // Track one accepted byte; on the final byte queue the refuse frame if due
  task automatic predict_refuse(input logic [7:0] b, input logic last);
    logic [7:0] rf[10];
    logic [7:0] chk;
    bit         login_ok;
    if (dg_pos == POS_HEAD) dg_head_ok = (b == FRAME_HEAD);
    if (dg_pos == POS_CMD) dg_cmd = b;
    if (dg_pos >= POS_SER_LO && dg_pos <= POS_SER_HI) dg_serial = {dg_serial[23:0], b};
    dg_prev_sum = dg_sum;
    dg_sum      = dg_sum + b;
    if (dg_pos < POS_SAT) dg_pos = dg_pos + 4'd1;
    if (last) begin
      login_ok = dg_head_ok && (b == FRAME_TAIL) && (dg_pos >= MIN_FRAME) &&
                 (dg_prev_sum == SUM_GOOD) && (dg_cmd == CMD_LOGIN) && (dg_pos >= MIN_LOGIN);
      if (login_ok) begin
        rf[0] = FRAME_HEAD;
        rf[1] = REPLY_LEN;
        rf[2] = ACK_CODE;
        rf[3] = REFUSE_CODE;
        rf[4] = dg_serial[31:24];
        rf[5] = dg_serial[23:16];
        rf[6] = dg_serial[15:8];
        rf[7] = dg_serial[7:0];
        chk = '0;
        for (int k = 0; k < 8; k++) chk = chk + rf[k];
        rf[8] = ~chk;
        rf[9] = FRAME_TAIL;
        for (int k = 0; k < 10; k++) refuse_bytes.push_back('{rf[k], k == 9});
      end
      dg_pos      = '0;
      dg_sum      = '0;
      dg_prev_sum = '0;
      dg_head_ok  = 1'b0;
      dg_cmd      = '0;
      dg_serial   = '0;
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic last, input bit drain);
    pending_bytes.push_back('{data, last, drain});
  endtask

  // Head, length/fix byte, command, body, tail; fix byte makes the sum good
  task automatic queue_frame(input logic [7:0] cmd, input int body_len,
                             input frame_flaw_e flaw, input int fill_val, input bit drain);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] tail;
    fb.push_back(FRAME_HEAD);
    fb.push_back(8'h00);
    fb.push_back(cmd);
    repeat (body_len) fb.push_back(fill_val < 0 ? 8'($urandom) : 8'(fill_val));
    if (flaw == FLAW_HEAD) begin
      fb[0] = 8'($urandom);
      if (fb[0] == FRAME_HEAD) fb[0] = ~FRAME_HEAD;
    end
    sum = '0;
    foreach (fb[k]) sum = sum + fb[k];
    fb[1] = SUM_GOOD - sum;
    if (flaw == FLAW_SUM) fb[1] = fb[1] ^ 8'(1 << $urandom_range(0, 7));
    tail = FRAME_TAIL;
    if (flaw == FLAW_TAIL) begin
      tail = 8'($urandom);
      if (tail == FRAME_TAIL) tail = ~FRAME_TAIL;
    end
    fb.push_back(tail);
    foreach (fb[k]) push_item(fb[k], k == fb.size() - 1, drain && k == 0);
  endtask

  // Random bytes, sometimes opening with a frame head
  task automatic queue_noise(input bit drain);
    int len;
    logic [7:0] b;
    len = $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom);
      if (k == 0 && $urandom_range(0, 3) == 0) b = FRAME_HEAD;
      push_item(b, k == len - 1, drain && k == 0);
    end
  endtask

  // Sender: next item at the falling edge, after any gap
  always @(negedge clk_i) begin : rx_driver
    logic     v;
    rx_item_t nx;
    v = rx_valid_i;
    if (rx_taken) begin
      v = 1'b0;
      rx_taken = 1'b0;
    end
    if (!rst_ni) begin
      v = 1'b0;
    end else if (!v) begin
      if (rx_gap > 0) begin
        rx_gap--;
      end else if (pending_bytes.size() > 0 &&
                   !(pending_bytes[0].drain && refuse_bytes.size() != 0)) begin
        nx = pending_bytes.pop_front();
        rx_byte_i <= nx.data;
        rx_last_i <= nx.last;
        v = 1'b1;
        rx_gap = calm_phase() ? 0 : pick_gap();
      end
    end
    rx_valid_i <= v;
  end

  // Receiver: random stalls, plus one long hold-off to fill the block
  always @(negedge clk_i) begin : reply_receiver
    logic s;
    s = 1'b0;
    if (squeeze_left > 0) begin
      squeeze_left--;
      s = 1'b1;
    end else if (!squeezed && rx_count >= SQUEEZE_AT) begin
      squeezed = 1'b1;
      squeeze_left = SQUEEZE_LEN - 1;
      s = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else if (!calm_phase() && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        s = 1'b1;
      end
    end
    reply_stall_i <= s;
  end

  // Monitor: check replies, feed accepted bytes to the predictor
  always @(posedge clk_i) begin : monitor
    reply_item_t want;
    cycle_count++;
    if (rst_ni) begin
      if (reply_valid_o && !reply_stall_i) begin
        if (refuse_bytes.size() == 0) begin
          $error("reply item with none expected: reply_byte %0h reply_last %0b",
                 reply_byte_o, reply_last_o);
          fail_count++;
        end else begin
          want = refuse_bytes.pop_front();
          if (reply_byte_o !== want.data) begin
            $error("reply_byte: expected %0h, actual %0h", want.data, reply_byte_o);
            fail_count++;
          end
          if (reply_last_o !== want.last) begin
            $error("reply_last: expected %0b, actual %0b", want.last, reply_last_o);
            fail_count++;
          end
        end
      end
      if (rx_valid_i && !rx_stall_o) begin
        predict_refuse(rx_byte_i, rx_last_i);
        rx_taken = 1'b1;
        rx_count++;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("login_frame_refuse_responder_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int          frame_idx;
    int          kind;
    int          n;
    int          total;
    logic [7:0]  cmd;
    frame_flaw_e flaw;
    bit          drain;

    // Directed: serial all zeros, serial all ones, short login, lone byte
    queue_frame(CMD_LOGIN, 4, FLAW_NONE, 8'h00, 1'b0);
    queue_frame(CMD_LOGIN, 4, FLAW_NONE, 8'hFF, 1'b0);
    queue_frame(CMD_LOGIN, 3, FLAW_NONE, -1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);

    // Random: mostly good login frames, plus other commands, short and broken ones
    total = pending_bytes.size() + RANDOM_BYTES;
    frame_idx = 0;
    while (pending_bytes.size() < total) begin
      kind  = $urandom_range(0, 99);
      drain = (frame_idx == 8) || (frame_idx == 40);
      if (kind < 55) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(4, 8);
        queue_frame(CMD_LOGIN, n, FLAW_NONE, -1, drain);
      end else if (kind < 65) begin
        cmd = 8'($urandom);
        if (cmd == CMD_LOGIN) cmd = cmd ^ 8'h01;
        queue_frame(cmd, $urandom_range(2, 8), FLAW_NONE, -1, drain);
      end else if (kind < 70) begin
        queue_frame(CMD_LOGIN, $urandom_range(2, 3), FLAW_NONE, -1, drain);
      end else if (kind < 85) begin
        flaw = frame_flaw_e'($urandom_range(FLAW_HEAD, FLAW_SUM));
        queue_frame(CMD_LOGIN, $urandom_range(0, 8), flaw, -1, drain);
      end else begin
        queue_noise(drain);
      end
      frame_idx++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_bytes.size() == 0 && rx_valid_i == 1'b0);
    wait (refuse_bytes.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_count == 0 && refuse_bytes.size() == 0) begin
      $display("login_frame_refuse_responder_unit: match");
    end else begin
      $display("login_frame_refuse_responder_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
sv/lfrr_pkg.sv
sv/lfrr_parser.sv
sv/lfrr_queue.sv
sv/lfrr_sender.sv
sv/login_frame_refuse_responder_unit.sv
tb/login_frame_refuse_responder_unit_test.sv
